// ===== rtl/hthfc_pkg.sv =====
// shared types and constants of the header/tail hash frame checker
// no dependencies; used by the front, queue, back and top modules
package hthfc_pkg;

    localparam logic [7:0] HASH_SEED = 8'h5A;
    localparam logic [7:0] HASH_MUL  = 8'd131;
    localparam int unsigned MIN_CHUNK = 3;
    localparam int unsigned QDEPTH = 4;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_SHORT     = 3'd1,
        ST_NO_HEADER = 3'd2,
        ST_NO_TAIL   = 3'd3,
        ST_MISMATCH  = 3'd4
    } t_status;

    // one queued job for the back end; status ok means compare tail with hash
    typedef struct packed {
        logic       has_pay;
        logic [7:0] pay_byte;
        logic       has_verdict;
        t_status    status;
        logic [7:0] tail;
    } t_cmd;

endpackage

// ===== rtl/hthfc_front.sv =====
// front end: accepts bytes, tracks header and held byte, classifies chunk end
// depends on hthfc_pkg for the job struct and status codes
module hthfc_front #(
    parameter int MAX_LEN = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    input  logic              i_full,
    output logic              o_push,
    output hthfc_pkg::t_cmd   o_cmd
);

    localparam int CW = $clog2(MAX_LEN + 1);

    logic [CW-1:0] r_count, n_count;
    logic          r_hs, n_hs;
    logic          r_hv, n_hv;
    logic [7:0]    r_held, n_held;
    logic [7:0]    r_header;

    logic          accept;
    logic [CW-1:0] total;
    logic          last;
    logic          short_chunk;

    assign o_cfg_ready = 1'b1;
    assign o_ready     = !i_full;
    assign accept      = i_valid && !i_full;
    assign total       = r_count + CW'(1);
    assign last        = i_last || (total >= CW'(MAX_LEN));
    assign short_chunk = total < CW'(hthfc_pkg::MIN_CHUNK);

    always_comb begin
        n_count = r_count;
        n_hs    = r_hs;
        n_hv    = r_hv;
        n_held  = r_held;
        o_push  = 1'b0;
        o_cmd   = '{has_pay: 1'b0, pay_byte: r_held, has_verdict: 1'b0,
                    status: hthfc_pkg::ST_OK, tail: i_byte};
        if (accept) begin
            n_count = total;
            if (!r_hs) begin
                if (i_byte == r_header) begin
                    n_hs = 1'b1;
                    o_cmd.status = short_chunk ? hthfc_pkg::ST_SHORT
                                               : hthfc_pkg::ST_NO_TAIL;
                end else begin
                    o_cmd.status = short_chunk ? hthfc_pkg::ST_SHORT
                                               : hthfc_pkg::ST_NO_HEADER;
                end
                o_cmd.has_verdict = last;
                o_push = last;
            end else if (!last) begin
                o_cmd.has_pay = r_hv;
                o_push = r_hv;
                n_held = i_byte;
                n_hv   = 1'b1;
            end else begin
                // tail byte: flush the held payload and ask for the compare, or flag a short chunk
                o_cmd.has_pay     = r_hv;
                o_cmd.has_verdict = 1'b1;
                o_cmd.status      = short_chunk ? hthfc_pkg::ST_SHORT
                                                : hthfc_pkg::ST_OK;
                o_push = 1'b1;
            end
            if (last) begin
                n_count = '0;
                n_hs    = 1'b0;
                n_hv    = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_hs     <= 1'b0;
            r_hv     <= 1'b0;
            r_header <= 8'd0;
        end else begin
            r_count <= n_count;
            r_hs    <= n_hs;
            r_hv    <= n_hv;
            if (i_cfg_valid) begin
                r_header <= i_cfg_data;
            end
        end
        r_held <= n_held;
    end

endmodule

// ===== rtl/hthfc_fifo.sv =====
// short job queue between front and back end
// depends on hthfc_pkg for the job struct and depth
module hthfc_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  hthfc_pkg::t_cmd i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output hthfc_pkg::t_cmd o_cmd
);

    localparam int AW = $clog2(hthfc_pkg::QDEPTH);

    hthfc_pkg::t_cmd r_mem [hthfc_pkg::QDEPTH];
    logic [AW-1:0]   r_wptr, r_rptr;
    logic [AW:0]     r_fill;

    assign o_full  = r_fill == (AW+1)'(hthfc_pkg::QDEPTH);
    assign o_valid = r_fill != '0;
    assign o_cmd   = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_fill <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + AW'(1);
            end
            if (i_pop) begin
                r_rptr <= r_rptr + AW'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_fill <= r_fill + (AW+1)'(1);
                2'b01:   r_fill <= r_fill - (AW+1)'(1);
                default: r_fill <= r_fill;
            endcase
        end
        if (i_push) begin
            r_mem[r_wptr] <= i_cmd;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full && !i_pop)) else $error("push into full queue");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> o_valid) else $error("pop from empty queue");
`endif

endmodule

// ===== rtl/hthfc_back.sv =====
// back end: runs queued jobs, keeps hash and payload count, drives result register
// depends on hthfc_pkg for the job struct, status codes and hash constants
module hthfc_back (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    input  hthfc_pkg::t_cmd i_cmd,
    output logic            o_pop,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [23:0]     o_data,  // payload_byte[7:0], frame_status[10:8], payload_length[18:11]
    output logic            o_user   // is_verdict
);

    logic       r_valid;
    logic       r_pay_done;
    logic [7:0] r_hash;
    logic [7:0] r_plen;
    logic       r_verdict;
    logic [7:0] r_pbyte;
    logic [2:0] r_status;
    logic [7:0] r_len;

    logic       load;
    logic       do_pay;
    logic [15:0] prod;
    logic [7:0] next_hash;
    hthfc_pkg::t_status vstat;

    assign load   = i_valid && (!r_valid || i_ready);
    assign do_pay = i_cmd.has_pay && !r_pay_done;
    assign o_pop  = load && (!do_pay || !i_cmd.has_verdict);
    assign prod   = 16'(r_hash) * 16'(hthfc_pkg::HASH_MUL);
    assign next_hash = prod[7:0] ^ i_cmd.pay_byte;

    always_comb begin
        vstat = i_cmd.status;
        if (i_cmd.status == hthfc_pkg::ST_OK && i_cmd.tail != r_hash) begin
            vstat = hthfc_pkg::ST_MISMATCH;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_pay_done <= 1'b0;
            r_hash     <= hthfc_pkg::HASH_SEED;
            r_plen     <= 8'd0;
        end else if (load) begin
            r_valid <= 1'b1;
            if (do_pay) begin
                r_hash     <= next_hash;
                r_plen     <= (r_plen == 8'hFF) ? r_plen : r_plen + 8'd1;
                r_pay_done <= i_cmd.has_verdict;
            end else begin
                r_hash     <= hthfc_pkg::HASH_SEED;
                r_plen     <= 8'd0;
                r_pay_done <= 1'b0;
            end
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
        if (load) begin
            r_verdict <= !do_pay;
            r_pbyte   <= do_pay ? i_cmd.pay_byte : 8'd0;
            r_status  <= do_pay ? 3'(hthfc_pkg::ST_OK) : 3'(vstat);
            r_len     <= do_pay ? 8'd0 : r_plen;
        end
    end

    assign o_valid = r_valid;
    assign o_user  = r_verdict;
    assign o_data  = {5'd0, r_len, r_status, r_pbyte};

`ifndef SYNTHESIS
    a_job_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pay_done |-> i_valid) else $error("split job lost its queue entry");
    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !r_verdict) |-> (r_status == 3'd0 && r_len == 8'd0))
        else $error("payload item carries verdict fields");
    a_hash_seeded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (load && !do_pay) |=> (r_hash == hthfc_pkg::HASH_SEED && r_plen == 8'd0))
        else $error("hash not reseeded after verdict");
`endif

endmodule

// ===== rtl/header_tail_hash_frame_check.sv =====
// header/tail hash frame checker: one byte per cycle in while the job queue is not full, no gaps needed
// a payload item is queued when the byte that follows it is taken, then registered in the back end's output;
// a verdict is queued with the chunk's last byte and leaves after the final payload if one goes first
// that final payload and verdict share one queue job and leave as two output items
// synchronous active-low reset clears counters, queue, hash and header register
module header_tail_hash_frame_check #(
    parameter int MAX_LEN = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data,     // header_byte
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte[7:0]
    input  logic        s_axis_tlast,   // chunk_end
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // payload_byte[7:0], frame_status[10:8], payload_length[18:11]
    output logic        m_axis_tuser    // is_verdict
);

    logic            push, full, pop, q_valid;
    hthfc_pkg::t_cmd push_cmd, head_cmd;

    hthfc_front #(.MAX_LEN(MAX_LEN)) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_data (i_cfg_data),
        .i_valid    (s_axis_tvalid),
        .o_ready    (s_axis_tready),
        .i_byte     (s_axis_tdata),
        .i_last     (s_axis_tlast),
        .i_full     (full),
        .o_push     (push),
        .o_cmd      (push_cmd)
    );

    hthfc_fifo u_fifo (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_cmd  (push_cmd),
        .o_full (full),
        .i_pop  (pop),
        .o_valid(q_valid),
        .o_cmd  (head_cmd)
    );

    hthfc_back u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(q_valid),
        .i_cmd  (head_cmd),
        .o_pop  (pop),
        .o_valid(m_axis_tvalid),
        .i_ready(m_axis_tready),
        .o_data (m_axis_tdata),
        .o_user (m_axis_tuser)
    );

endmodule

// ===== tb/sv/header_tail_hash_frame_check_tb.sv =====
// self-checking bench for header_tail_hash_frame_check: byte chunks in, items and verdicts out
// depends on hthfc_pkg (status codes, hash seed and multiplier) and the top-level rtl module
module header_tail_hash_frame_check_tb;

    localparam int CLK_PERIOD   = 12;
    localparam int MAX_LEN      = 256;
    localparam int LIMIT_CYCLES = 400000;
    localparam int PHASE_ITEMS  = 110;

    typedef struct {
        logic [7:0] data;
        logic       last;
        logic       drain;
    } t_rx_item;

    typedef struct {
        logic                  is_verdict;
        logic [7:0]            pay;
        hthfc_pkg::t_status    st;
        logic [7:0]            len;
    } t_frame_out;

    typedef enum {CK_FRAME, CK_NOHDR, CK_SHORT, CK_HDR_LATE, CK_JUNK, CK_LONG} t_chunk_kind;
    typedef enum {RDY_ALWAYS, RDY_RANDOM, RDY_PERIODIC, RDY_BURSTY} t_ready_style;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data = 8'h00;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;    // rx_byte[7:0]
    logic        s_axis_tlast = 1'b0;     // chunk_end
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [23:0] m_axis_tdata;            // payload_byte[7:0], frame_status[10:8], payload_length[18:11]
    logic        m_axis_tuser;            // is_verdict

    header_tail_hash_frame_check #(.MAX_LEN(MAX_LEN)) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    t_rx_item   rx_bytes_q[$];
    t_frame_out frame_out_q[$];

    // predicted state of the checker
    logic [7:0] hdr_cfg = 8'h00;
    int         rx_cnt = 0;
    logic       hdr_found = 1'b0;
    logic       held_ok = 1'b0;
    logic [7:0] held_byte = 8'h00;
    logic [7:0] run_hash = hthfc_pkg::HASH_SEED;
    logic [7:0] pay_cnt = 8'h00;

    int err_cnt = 0;
    int bytes_sent = 0;
    int pay_seen = 0;
    int hdr_settings = 0;
    int st_seen[5] = '{0, 0, 0, 0, 0};
    logic drain_next = 1'b0;

    int gap_left = 0;
    int burst_left = 0;
    bit steady = 1'b0;
    t_ready_style rdy_style = RDY_ALWAYS;
    int rdy_tick = 0;
    int rdy_hold = 0;

    function automatic logic [7:0] hash_step(input logic [7:0] h, input logic [7:0] b);
        logic [15:0] p;
        p = h * hthfc_pkg::HASH_MUL;
        return p[7:0] ^ b;
    endfunction

    function automatic logic [7:0] other_than(input logic [7:0] h);
        logic [7:0] d;
        d = 8'($urandom);
        return (d == h) ? ~d : d;
    endfunction

    task automatic close_frame(input hthfc_pkg::t_status st);
        t_frame_out v;
        v.is_verdict = 1'b1;
        v.pay = 8'h00;
        v.st = st;
        v.len = pay_cnt;
        frame_out_q.push_back(v);
        rx_cnt = 0;
        hdr_found = 1'b0;
        held_ok = 1'b0;
        held_byte = 8'h00;
        run_hash = hthfc_pkg::HASH_SEED;
        pay_cnt = 8'h00;
    endtask

    task automatic track_rx_byte(input logic [7:0] b, input logic end_flag);
        t_frame_out v;
        int total;
        logic closes;
        total = rx_cnt + 1;
        closes = end_flag || (total >= MAX_LEN);
        rx_cnt = total;
        if (!hdr_found) begin
            if (b == hdr_cfg) hdr_found = 1'b1;
            if (closes)
                close_frame((total < hthfc_pkg::MIN_CHUNK) ? hthfc_pkg::ST_SHORT :
                            (hdr_found ? hthfc_pkg::ST_NO_TAIL : hthfc_pkg::ST_NO_HEADER));
        end else begin
            // the held byte turns out to be payload once any later byte shows up
            if (held_ok) begin
                v.is_verdict = 1'b0;
                v.pay = held_byte;
                v.st = hthfc_pkg::ST_OK;
                v.len = 8'h00;
                frame_out_q.push_back(v);
                run_hash = hash_step(run_hash, held_byte);
                if (pay_cnt != 8'hFF) pay_cnt = pay_cnt + 8'd1;
            end
            if (!closes) begin
                held_byte = b;
                held_ok = 1'b1;
            end else if (total < hthfc_pkg::MIN_CHUNK) begin
                close_frame(hthfc_pkg::ST_SHORT);
            end else begin
                close_frame((b != run_hash) ? hthfc_pkg::ST_MISMATCH : hthfc_pkg::ST_OK);
            end
        end
    endtask

    task automatic push_byte(input logic [7:0] d, input logic last);
        t_rx_item it;
        it.data = d;
        it.last = last;
        it.drain = drain_next;
        drain_next = 1'b0;
        rx_bytes_q.push_back(it);
        bytes_sent++;
    endtask

    task automatic add_chunk(input t_chunk_kind kind, input logic drain);
        int n_noise;
        int n_pay;
        int len;
        logic [7:0] h;
        logic [7:0] d;
        logic [7:0] tail;
        h = hdr_cfg;
        drain_next = drain;
        case (kind)
            CK_FRAME, CK_LONG: begin
                n_noise = $urandom_range(0, 3);
                if (kind == CK_LONG) n_pay = MAX_LEN - 2 - n_noise;
                else if ($urandom_range(0, 7) == 0) n_pay = $urandom_range(21, 80);
                else n_pay = $urandom_range(0, 20);
                for (int i = 0; i < n_noise; i++) push_byte(other_than(h), 1'b0);
                push_byte(h, 1'b0);
                tail = hthfc_pkg::HASH_SEED;
                for (int i = 0; i < n_pay; i++) begin
                    d = 8'($urandom);
                    tail = hash_step(tail, d);
                    push_byte(d, 1'b0);
                end
                if ($urandom_range(0, 6) == 0) tail = tail ^ 8'($urandom_range(1, 255));
                // a long chunk may also close on its byte count alone
                push_byte(tail, (kind == CK_LONG) ? 1'($urandom_range(0, 1)) : 1'b1);
            end
            CK_NOHDR: begin
                len = $urandom_range(1, 10);
                for (int i = 0; i < len; i++) push_byte(other_than(h), i == len - 1);
            end
            CK_SHORT: begin
                len = $urandom_range(1, 2);
                for (int i = 0; i < len; i++) push_byte(8'($urandom), i == len - 1);
            end
            CK_HDR_LATE: begin
                n_noise = $urandom_range(0, 4);
                for (int i = 0; i < n_noise; i++) push_byte(other_than(h), 1'b0);
                if ($urandom_range(0, 1) == 0) begin
                    push_byte(h, 1'b1);
                end else begin
                    push_byte(h, 1'b0);
                    push_byte(($urandom_range(0, 1) == 0) ? hthfc_pkg::HASH_SEED : 8'($urandom),
                              1'b1);
                end
            end
            default: begin
                len = $urandom_range(1, 12);
                for (int i = 0; i < len; i++)
                    push_byte(($urandom_range(0, 4) == 0) ? h : 8'($urandom), i == len - 1);
            end
        endcase
    endtask

    // block is idle once nothing is queued, nothing is on the bus and nothing is owed
    task automatic wait_idle();
        do @(posedge i_clk);
        while (rx_bytes_q.size() != 0 || s_axis_tvalid || frame_out_q.size() != 0);
        repeat (10) @(posedge i_clk);
    endtask

    task automatic write_header(input logic [7:0] v);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        hdr_cfg = v;
        hdr_settings++;
        i_cfg_valid <= 1'b0;
    endtask

    // sender: bursts of random length with random gaps
    always @(posedge i_clk) begin
        t_rx_item it;
        logic fire;
        fire = s_axis_tvalid && s_axis_tready;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (s_axis_tvalid && !s_axis_tready) begin
            // hold the item until it is taken
        end else if (gap_left > 0) begin
            gap_left--;
            s_axis_tvalid <= 1'b0;
        end else if (rx_bytes_q.size() != 0 &&
                     !(rx_bytes_q[0].drain && (fire || frame_out_q.size() != 0))) begin
            it = rx_bytes_q.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= it.data;
            s_axis_tlast <= it.last;
            if (burst_left > 1) begin
                burst_left--;
            end else begin
                burst_left = $urandom_range(1, 48);
                if (steady || $urandom_range(0, 2) == 0) gap_left = 0;
                else gap_left = $urandom_range(1, 6);
            end
        end else begin
            s_axis_tvalid <= 1'b0;
        end
    end

    // receiver stall pattern, style chosen per phase
    always @(posedge i_clk) begin
        rdy_tick++;
        case (rdy_style)
            RDY_ALWAYS: m_axis_tready <= 1'b1;
            RDY_RANDOM: m_axis_tready <= ($urandom_range(0, 9) < 7);
            RDY_PERIODIC: m_axis_tready <= ((rdy_tick % 7) > 2);
            default: begin
                if (rdy_hold > 0) begin
                    rdy_hold--;
                    m_axis_tready <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    rdy_hold = $urandom_range(4, 12);
                    m_axis_tready <= 1'b0;
                end else begin
                    m_axis_tready <= 1'b1;
                end
            end
        endcase
    end

    // predict on every taken byte, then check every delivered item
    always @(posedge i_clk) begin
        t_frame_out want;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) track_rx_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) begin
                if (frame_out_q.size() == 0) begin
                    err_cnt++;
                    if (err_cnt <= 10)
                        $display("%0t: unexpected item, verdict %0b tdata %h",
                                 $time, m_axis_tuser, m_axis_tdata);
                end else begin
                    want = frame_out_q.pop_front();
                    if (m_axis_tuser !== want.is_verdict || m_axis_tdata[7:0] !== want.pay ||
                        m_axis_tdata[10:8] !== want.st || m_axis_tdata[18:11] !== want.len ||
                        m_axis_tdata[23:19] !== 5'd0) begin
                        err_cnt++;
                        if (err_cnt <= 10) begin
                            $write("%0t: mismatch, expected verdict %0b byte %h status %0d len %0d",
                                   $time, want.is_verdict, want.pay, want.st, want.len);
                            $display(", got verdict %0b byte %h status %0d len %0d pad %h",
                                     m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[10:8],
                                     m_axis_tdata[18:11], m_axis_tdata[23:19]);
                        end
                    end
                    if (want.is_verdict) st_seen[int'(want.st)]++;
                    else pay_seen++;
                end
            end
        end
    end

    initial begin
        logic [7:0] hdr_plan[5];
        t_ready_style style_plan[5];
        t_chunk_kind kind;
        int r;
        int target;
        int chunk_no;
        logic [7:0] t;
        hdr_plan = '{8'h00, 8'hFF, 8'($urandom), hthfc_pkg::HASH_SEED, 8'($urandom)};
        style_plan = '{RDY_RANDOM, RDY_BURSTY, RDY_ALWAYS, RDY_PERIODIC, RDY_RANDOM};
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int p = 0; p < 5; p++) begin
            if (p > 0) wait_idle();
            write_header(hdr_plan[p]);
            rdy_style = style_plan[p];
            steady = (style_plan[p] == RDY_ALWAYS);
            if (p == 0) begin
                // header alone, header last of two, header then tail only: all too short
                push_byte(8'h00, 1'b1);
                push_byte(8'h80, 1'b0);
                push_byte(8'h00, 1'b1);
                push_byte(8'h00, 1'b0);
                push_byte(hthfc_pkg::HASH_SEED, 1'b1);
                // no header at all
                push_byte(8'hFF, 1'b0);
                push_byte(8'h7F, 1'b0);
                push_byte(8'h01, 1'b1);
                // header on the last byte leaves no room for the tail
                push_byte(8'hFF, 1'b0);
                push_byte(8'hAA, 1'b0);
                push_byte(8'h00, 1'b1);
                // header on the next to last byte: empty payload, tail is the seed
                push_byte(8'h55, 1'b0);
                push_byte(8'h00, 1'b0);
                push_byte(hthfc_pkg::HASH_SEED, 1'b1);
                // good frame with extreme payload bytes
                push_byte(8'h00, 1'b0);
                push_byte(8'hFF, 1'b0);
                push_byte(8'h00, 1'b0);
                push_byte(hash_step(hash_step(hthfc_pkg::HASH_SEED, 8'hFF), 8'h00), 1'b1);
                // bad tail: the payload still comes out, the verdict still counts it
                t = hash_step(hthfc_pkg::HASH_SEED, 8'h01) ^ 8'h01;
                push_byte(8'h00, 1'b0);
                push_byte(8'h01, 1'b0);
                push_byte(t, 1'b1);
            end
            if (p == 1) add_chunk(CK_LONG, 1'b0);
            target = bytes_sent + PHASE_ITEMS;
            chunk_no = 0;
            while (bytes_sent < target) begin
                r = $urandom_range(0, 99);
                if (r < 60) kind = CK_FRAME;
                else if (r < 68) kind = CK_NOHDR;
                else if (r < 76) kind = CK_SHORT;
                else if (r < 86) kind = CK_HDR_LATE;
                else kind = CK_JUNK;
                add_chunk(kind, (chunk_no == 5) || ($urandom_range(0, 11) == 0));
                chunk_no++;
            end
        end
        wait_idle();
        $display("covered %0d bytes under %0d header settings: %0d payload items checked",
                 bytes_sent, hdr_settings, pay_seen);
        $display("verdicts: ok %0d, too short %0d, no header %0d, no tail room %0d, bad hash %0d",
                 st_seen[0], st_seen[1], st_seen[2], st_seen[3], st_seen[4]);
        if (frame_out_q.size() != 0)
            $display("%0d expected items never arrived", frame_out_q.size());
        if (err_cnt == 0 && frame_out_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("mismatches: %0d", err_cnt);
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d items still expected", frame_out_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/hthfc_pkg.sv
rtl/hthfc_front.sv
rtl/hthfc_fifo.sv
rtl/hthfc_back.sv
rtl/header_tail_hash_frame_check.sv
tb/sv/header_tail_hash_frame_check_tb.sv
